>>> rtl/cts_pkg.sv
// Shared types, codes and widths for the cooperative task scheduler.
package cts_pkg;

    // Fixed field widths
    localparam int DATA_W    = 32;
    localparam int RUN_W     = 8;
    localparam int TASK_ID_W = 4;
    localparam int CMD_W     = 3;
    localparam int STATUS_W  = 2;

    // Tick-length division: reciprocal multiply in two partial-product steps
    localparam int MUL_STEPS = 2;
    localparam int DIV_CNT_W = $clog2(MUL_STEPS);

    // Defaults for the top-level parameters
    localparam int MAX_TASKS_DEF = 8;
    localparam int TICK_MS_DEF   = 10;

    // Saturation point of the pending-run count
    localparam logic [RUN_W-1:0] RUNS_MAX = '1;

    typedef logic [TASK_ID_W-1:0] t_task_id;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD      = 3'd0,
        CMD_TICK     = 3'd1,
        CMD_DISPATCH = 3'd2,
        CMD_DELETE   = 3'd3,
        CMD_CLEAR    = 3'd4
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_BAD_ID = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD_DIV,
        S_ADD_END,
        S_TICK,
        S_DISP,
        S_DEL,
        S_CLR
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic div_step;
        logic add_end;
        logic tick_step;
        logic disp_step;
        logic del_end;
        logic clr;
    } t_dp_ctl;

    // Datapath to controller status
    typedef struct packed {
        logic div_done;
        logic scan_end;
    } t_dp_sts;

endpackage

>>> rtl/cts_ctrl.sv
// Command sequencer for the cooperative task scheduler.
module cts_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [cts_pkg::CMD_W-1:0] i_cmd,
    input  cts_pkg::t_dp_sts          i_sts,
    output cts_pkg::t_dp_ctl          o_ctl,
    output logic                      o_busy
);
    import cts_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign w_accept = i_start && (r_state == S_IDLE);
    assign o_busy   = (r_state != S_IDLE);

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_cmd)
                        CMD_ADD:      n_state = S_ADD_DIV;
                        CMD_TICK:     n_state = S_TICK;
                        CMD_DISPATCH: n_state = S_DISP;
                        CMD_DELETE:   n_state = S_DEL;
                        CMD_CLEAR:    n_state = S_CLR;
                        default:      n_state = S_IDLE;
                    endcase
                end
            end
            S_ADD_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_ADD_END;
                end
            end
            S_ADD_END: n_state = S_IDLE;
            S_TICK, S_DISP: begin
                if (i_sts.scan_end) begin
                    n_state = S_IDLE;
                end
            end
            S_DEL:   n_state = S_IDLE;
            S_CLR:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath commands
    always_comb begin
        o_ctl = '0;
        case (r_state)
            S_IDLE:    o_ctl.load      = w_accept;
            S_ADD_DIV: o_ctl.div_step  = 1'b1;
            S_ADD_END: o_ctl.add_end   = 1'b1;
            S_TICK:    o_ctl.tick_step = 1'b1;
            S_DISP:    o_ctl.disp_step = 1'b1;
            S_DEL:     o_ctl.del_end   = 1'b1;
            S_CLR:     o_ctl.clr       = 1'b1;
            default:   o_ctl           = '0;
        endcase
    end

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_ctl))
        else $error("more than one datapath command at once");

    a_div_to_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD_DIV && i_sts.div_done) |=> (r_state == S_ADD_END))
        else $error("add did not finish after division");

    a_scan_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_TICK || r_state == S_DISP) && i_sts.scan_end) |=> !o_busy)
        else $error("scan did not return to idle");

endmodule

>>> rtl/cts_dp.sv
// Slot table, tick divider and result register of the cooperative task scheduler.
module cts_dp #(
    parameter int MAX_TASKS = cts_pkg::MAX_TASKS_DEF,
    parameter int TICK_MS   = cts_pkg::TICK_MS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  cts_pkg::t_dp_ctl             i_ctl,
    output cts_pkg::t_dp_sts             o_sts,
    input  logic [cts_pkg::DATA_W-1:0]   i_delay_ms,
    input  logic [cts_pkg::DATA_W-1:0]   i_period_ms,
    input  logic [cts_pkg::TASK_ID_W-1:0] i_target_id,
    output logic                         o_strobe,
    output logic [cts_pkg::TASK_ID_W-1:0] o_task_id,
    output logic                         o_run_valid,
    output logic [cts_pkg::STATUS_W-1:0] o_status,
    output logic                         o_last
);
    import cts_pkg::*;

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W = $clog2(MAX_TASKS + 1);

    // Rounded-up reciprocal of the tick length, exact for every 32-bit operand
    localparam int L_SH    = $clog2(TICK_MS);
    localparam int RECIP_W = DATA_W + 1;
    localparam int LO_W    = (RECIP_W + 1) / 2;
    localparam int HI_W    = RECIP_W - LO_W;
    localparam int PART_W  = DATA_W + LO_W;
    localparam int PROD_W  = DATA_W + RECIP_W;

    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << (DATA_W + L_SH)) + 64'(TICK_MS - 1)) / 64'(TICK_MS));
    localparam logic [LO_W-1:0] RECIP_LO = RECIP[LO_W-1:0];
    localparam logic [LO_W-1:0] RECIP_HI = LO_W'(RECIP[RECIP_W-1:LO_W]);

    localparam logic [IDX_W-1:0]     LAST_IDX = IDX_W'(MAX_TASKS - 1);
    localparam logic [CNT_W-1:0]     SLOT_MAX = CNT_W'(MAX_TASKS);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(MUL_STEPS - 1);
    localparam t_task_id             FULL_ID  = TASK_ID_W'(MAX_TASKS);

    // Slot table
    logic [DATA_W-1:0]    r_delay   [MAX_TASKS];
    logic [DATA_W-1:0]    r_period  [MAX_TASKS];
    logic [RUN_W-1:0]     r_pending [MAX_TASKS];
    logic [MAX_TASKS-1:0] r_in_use;
    logic [CNT_W-1:0]     r_next_slot;

    // Sequencing counters
    logic [IDX_W-1:0]     r_scan;
    logic [DIV_CNT_W-1:0] r_div_cnt;

    // Latched operands and product accumulators
    logic [DATA_W-1:0]    r_op_dly;
    logic [DATA_W-1:0]    r_op_per;
    logic [PROD_W-1:0]    r_acc_dly;
    logic [PROD_W-1:0]    r_acc_per;
    t_task_id             r_target;

    // Result register
    logic                 r_strobe;
    t_task_id             r_task_id;
    logic                 r_run_valid;
    t_status              r_status;
    logic                 r_last;

    logic [LO_W-1:0]      w_recip_part;
    logic [PART_W-1:0]    w_dly_part;
    logic [PART_W-1:0]    w_per_part;
    logic [DATA_W-1:0]    w_dly_ticks;
    logic [DATA_W-1:0]    w_per_ticks;
    logic                 w_full;
    logic [IDX_W-1:0]     w_add_idx;
    logic [IDX_W-1:0]     w_tgt_idx;
    logic                 w_del_ok;
    logic [MAX_TASKS-1:0] w_pend_vec;
    logic [MAX_TASKS-1:0] w_above;
    logic                 w_more;
    logic                 w_cur_live;
    logic                 w_cur_pend;
    logic [DATA_W-1:0]    w_cur_dly;
    logic [DATA_W-1:0]    w_cur_per;
    logic [RUN_W-1:0]     w_cur_runs;
    logic                 w_beat;

    // Divide by the tick length: low then high half of the reciprocal, keep the top bits
    assign w_recip_part = (r_div_cnt == '0) ? RECIP_LO : RECIP_HI;
    assign w_dly_part   = PART_W'(r_op_dly) * PART_W'(w_recip_part);
    assign w_per_part   = PART_W'(r_op_per) * PART_W'(w_recip_part);
    assign w_dly_ticks  = DATA_W'(r_acc_dly >> (DATA_W + L_SH));
    assign w_per_ticks  = DATA_W'(r_acc_per >> (DATA_W + L_SH));

    // Add and delete decode
    assign w_full    = (r_next_slot >= SLOT_MAX);
    assign w_add_idx = r_next_slot[IDX_W-1:0];
    assign w_tgt_idx = r_target[IDX_W-1:0];
    assign w_del_ok  = (r_target < FULL_ID) && r_in_use[w_tgt_idx];

    // Current scan slot
    assign w_cur_live = r_in_use[r_scan];
    assign w_cur_dly  = r_delay[r_scan];
    assign w_cur_per  = r_period[r_scan];
    assign w_cur_runs = r_pending[r_scan];
    assign w_cur_pend = w_pend_vec[r_scan];

    // Look ahead for later slots with runs owed, to flag the final dispatch beat
    always_comb begin
        for (int j = 0; j < MAX_TASKS; j++) begin
            w_pend_vec[j] = r_in_use[j] && (r_pending[j] != '0);
            w_above[j]    = (IDX_W'(j) > r_scan);
        end
    end
    assign w_more = |(w_pend_vec & w_above);

    // Raise a beat for add, delete and each dispatched run
    assign w_beat = i_ctl.add_end || i_ctl.del_end || (i_ctl.disp_step && w_cur_pend);

    assign o_sts.div_done = (r_div_cnt == DIV_LAST);
    assign o_sts.scan_end = (r_scan == LAST_IDX);

    // Control state: occupancy, allocation pointer, counters, strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use    <= '0;
            r_next_slot <= '0;
            r_scan      <= '0;
            r_div_cnt   <= '0;
            r_strobe    <= 1'b0;
        end else begin
            r_strobe <= w_beat;
            if (i_ctl.load) begin
                r_scan    <= '0;
                r_div_cnt <= '0;
            end
            if (i_ctl.div_step) begin
                r_div_cnt <= r_div_cnt + 1'b1;
            end
            if (i_ctl.tick_step || i_ctl.disp_step) begin
                r_scan <= r_scan + 1'b1;
            end
            if (i_ctl.clr) begin
                r_in_use    <= '0;
                r_next_slot <= '0;
            end
            if (i_ctl.add_end) begin
                if (!w_full) begin
                    r_in_use[w_add_idx] <= 1'b1;
                    r_next_slot         <= r_next_slot + 1'b1;
                end
            end
            // Free one-shot tasks once their run goes out
            if (i_ctl.disp_step && w_cur_pend) begin
                if (w_cur_per == '0) begin
                    r_in_use[r_scan] <= 1'b0;
                end
            end
            if (i_ctl.del_end) begin
                if (w_del_ok) begin
                    r_in_use[w_tgt_idx] <= 1'b0;
                end
            end
        end
    end

    // Payload: operands, divider, slot contents, result fields
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_op_dly <= i_delay_ms;
            r_op_per <= i_period_ms;
            r_target <= i_target_id;
        end
        if (i_ctl.div_step) begin
            if (r_div_cnt == '0) begin
                r_acc_dly <= PROD_W'(w_dly_part);
                r_acc_per <= PROD_W'(w_per_part);
            end else begin
                r_acc_dly <= r_acc_dly + {w_dly_part[DATA_W+HI_W-1:0], {LO_W{1'b0}}};
                r_acc_per <= r_acc_per + {w_per_part[DATA_W+HI_W-1:0], {LO_W{1'b0}}};
            end
        end
        if (i_ctl.add_end) begin
            if (!w_full) begin
                r_delay[w_add_idx]   <= w_dly_ticks;
                r_period[w_add_idx]  <= w_per_ticks;
                r_pending[w_add_idx] <= '0;
            end
            r_task_id   <= w_full ? FULL_ID : t_task_id'(r_next_slot);
            r_run_valid <= 1'b0;
            r_status    <= w_full ? ST_FULL : ST_OK;
            r_last      <= 1'b1;
        end
        // Count down, or reload and owe one more run up to the saturation point
        if (i_ctl.tick_step && w_cur_live) begin
            if (w_cur_dly != '0) begin
                r_delay[r_scan] <= w_cur_dly - 1'b1;
            end else begin
                r_delay[r_scan] <= w_cur_per;
                if (w_cur_runs != RUNS_MAX) begin
                    r_pending[r_scan] <= w_cur_runs + 1'b1;
                end
            end
        end
        if (i_ctl.disp_step && w_cur_pend) begin
            r_pending[r_scan] <= w_cur_runs - 1'b1;
            r_task_id         <= t_task_id'(r_scan);
            r_run_valid       <= 1'b1;
            r_status          <= ST_OK;
            r_last            <= !w_more;
        end
        if (i_ctl.del_end) begin
            r_task_id   <= r_target;
            r_run_valid <= 1'b0;
            r_status    <= w_del_ok ? ST_OK : ST_BAD_ID;
            r_last      <= 1'b1;
        end
    end

    assign o_strobe    = r_strobe;
    assign o_task_id   = r_task_id;
    assign o_run_valid = r_run_valid;
    assign o_status    = r_status;
    assign o_last      = r_last;

    a_next_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_slot <= SLOT_MAX)
        else $error("allocation pointer past the table");

    a_no_live_beyond: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_use >> r_next_slot) == '0)
        else $error("slot in use that was never handed out");

    a_run_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_run_valid) |-> (o_status == ST_OK))
        else $error("dispatch beat with error status");

endmodule

>>> rtl/cooperative_task_scheduler_core.sv
// Top level of the time-triggered cooperative task scheduler.
//
//  Channel   | Handshake              | Payload
//  ----------+------------------------+---------------------------------------------
//  command   | start / busy           | i_cmd, i_delay_ms, i_period_ms, i_target_id
//  result    | o_strobe (one cycle)   | o_task_id, o_run_valid, o_status, o_last
//
// A command is taken on a clock edge with start high and busy low.
// Add takes the command, then runs two partial-product steps of the reciprocal multiply
// by the tick length (delay and period side by side), then writes the slot.
// Tick and dispatch scan the table, visiting one slot a cycle.
// Delete and clear act on the table. Each result beat appears in the cycle after its work.
// Reset (synchronous, active low) frees every slot; the receiver cannot stall.
module cooperative_task_scheduler_core #(
    parameter int MAX_TASKS = cts_pkg::MAX_TASKS_DEF,
    parameter int TICK_MS   = cts_pkg::TICK_MS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [cts_pkg::CMD_W-1:0]     i_cmd,
    input  logic [cts_pkg::DATA_W-1:0]    i_delay_ms,
    input  logic [cts_pkg::DATA_W-1:0]    i_period_ms,
    input  logic [cts_pkg::TASK_ID_W-1:0] i_target_id,
    output logic                          o_strobe,
    output logic [cts_pkg::TASK_ID_W-1:0] o_task_id,
    output logic                          o_run_valid,
    output logic [cts_pkg::STATUS_W-1:0]  o_status,
    output logic                          o_last
);
    import cts_pkg::*;

    t_dp_ctl w_ctl;
    t_dp_sts w_sts;

    // Sequence each command
    cts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cmd   (i_cmd),
        .i_sts   (w_sts),
        .o_ctl   (w_ctl),
        .o_busy  (busy)
    );

    // Hold the slot table and produce result beats
    cts_dp #(
        .MAX_TASKS (MAX_TASKS),
        .TICK_MS   (TICK_MS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .o_sts       (w_sts),
        .i_delay_ms  (i_delay_ms),
        .i_period_ms (i_period_ms),
        .i_target_id (i_target_id),
        .o_strobe    (o_strobe),
        .o_task_id   (o_task_id),
        .o_run_valid (o_run_valid),
        .o_status    (o_status),
        .o_last      (o_last)
    );

endmodule

>>> tb/sv/cooperative_task_scheduler_core_test.sv
// Self-checking testbench for the cooperative task scheduler core.
`timescale 1ns / 1ps

module cooperative_task_scheduler_core_test;
    import cts_pkg::*;

    localparam int MAX_TASKS    = MAX_TASKS_DEF;
    localparam int TICK_MS      = TICK_MS_DEF;
    localparam int RAND_ITEMS   = 75;       // counted commands per idling phase
    localparam int DRAIN_CYCLES = 2 * (DATA_W + 2 + MAX_TASKS + 1);
    localparam int LIMIT_CYCLES = 400000;
    localparam int NUM_DIRECTED = 27;

    // Codes the block has to ignore
    localparam logic [CMD_W-1:0] CMD_RSVD_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD_HI = 3'd7;

    // One result beat as it leaves the block
    typedef struct packed {
        t_task_id task_id;
        logic     run_valid;
        t_status  status;
        logic     last;
    } sched_beat_t;

    // One row of the directed stimulus; typed rows carry their own answer
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [DATA_W-1:0] delay_ms;
        logic [DATA_W-1:0] period_ms;
        t_task_id          target;
        logic              typed;
        t_task_id          want_id;
        t_status           want_status;
    } stim_row_t;

    localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
        '{CMD_ADD,      32'd0,        32'd0,        4'd0,  1'b1, 4'd0,  ST_OK},
        '{CMD_ADD,      32'd9,        32'd10,       4'd0,  1'b0, 4'd0,  ST_OK},
        '{CMD_ADD,      32'hFFFFFFFF, 32'hFFFFFFFF, 4'd0,  1'b0, 4'd0,  ST_OK},
        '{CMD_ADD,      32'd25,       32'd30,       4'd0,  1'b0, 4'd0,  ST_OK},
        '{CMD_DISPATCH, 32'd0,        32'd0,        4'd0,  1'b0, 4'd0,  ST_OK},
        '{CMD_TICK,     32'd0,        32'd0,        4'd0,  1'b0, 4'd0,  ST_OK},
        '{CMD_DISPATCH, 32'd0,        32'd0,        4'd0,  1'b0, 4'd0,  ST_OK},
        '{CMD_TICK,     32'hFFFFFFFF, 32'hFFFFFFFF, 4'hF,  1'b0, 4'd0,  ST_OK},
        '{CMD_TICK,     32'd0,        32'd0,        4'd0,  1'b0, 4'd0,  ST_OK},
        '{CMD_TICK,     32'd0,        32'd0,        4'd0,  1'b0, 4'd0,  ST_OK},
        '{CMD_DISPATCH, 32'd0,        32'd0,        4'd0,  1'b0, 4'd0,  ST_OK},
        '{CMD_DELETE,   32'd0,        32'd0,        4'd0,  1'b0, 4'd0,  ST_OK},
        '{CMD_DELETE,   32'd0,        32'd0,        4'd15, 1'b1, 4'd15, ST_BAD_ID},
        '{CMD_DELETE,   32'd0,        32'd0,        4'd8,  1'b1, 4'd8,  ST_BAD_ID},
        '{CMD_DELETE,   32'd0,        32'd0,        4'd2,  1'b1, 4'd2,  ST_OK},
        '{CMD_RSVD_LO,  32'hFFFFFFFF, 32'hFFFFFFFF, 4'hF,  1'b0, 4'd0,  ST_OK},
        '{CMD_RSVD_HI,  32'd0,        32'd0,        4'd0,  1'b0, 4'd0,  ST_OK},
        '{CMD_ADD,      32'd10,       32'd20,       4'd0,  1'b0, 4'd0,  ST_OK},
        '{CMD_ADD,      32'd0,        32'd5,        4'd0,  1'b0, 4'd0,  ST_OK},
        '{CMD_ADD,      32'd0,        32'd0,        4'd0,  1'b0, 4'd0,  ST_OK},
        '{CMD_ADD,      32'hFFFFFFFF, 32'd0,        4'd0,  1'b0, 4'd0,  ST_OK},
        '{CMD_ADD,      32'd0,        32'd0,        4'd0,  1'b1, 4'd8,  ST_FULL},
        '{CMD_TICK,     32'd0,        32'd0,        4'd0,  1'b0, 4'd0,  ST_OK},
        '{CMD_DISPATCH, 32'd0,        32'd0,        4'd0,  1'b0, 4'd0,  ST_OK},
        '{CMD_CLEAR,    32'd0,        32'd0,        4'd0,  1'b0, 4'd0,  ST_OK},
        '{CMD_ADD,      32'd0,        32'd0,        4'd0,  1'b1, 4'd0,  ST_OK},
        '{CMD_DELETE,   32'd0,        32'd0,        4'd0,  1'b1, 4'd0,  ST_OK}
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [CMD_W-1:0]     i_cmd;
    logic [DATA_W-1:0]    i_delay_ms;
    logic [DATA_W-1:0]    i_period_ms;
    logic [TASK_ID_W-1:0] i_target_id;
    logic                 o_strobe;
    logic [TASK_ID_W-1:0] o_task_id;
    logic                 o_run_valid;
    logic [STATUS_W-1:0]  o_status;
    logic                 o_last;

    // Answer of the row on the bus, when it is typed in
    logic     row_typed;
    t_task_id row_id;
    t_status  row_status;

    // Shadow copy of the task table
    logic [DATA_W-1:0] sl_delay  [MAX_TASKS];
    logic [DATA_W-1:0] sl_period [MAX_TASKS];
    logic [RUN_W-1:0]  sl_runs   [MAX_TASKS];
    logic              sl_live   [MAX_TASKS];
    int unsigned       sl_next;

    sched_beat_t expected_beats [$];
    sched_beat_t want;

    int idle_pct;
    int mismatch_count;
    int cycle_count;
    int beats_checked;
    int run_beats;
    int full_adds;
    int bad_deletes;
    int sat_ticks;
    int cmd_seen [8];

    cooperative_task_scheduler_core #(
        .MAX_TASKS(MAX_TASKS),
        .TICK_MS  (TICK_MS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_cmd      (i_cmd),
        .i_delay_ms (i_delay_ms),
        .i_period_ms(i_period_ms),
        .i_target_id(i_target_id),
        .o_strobe   (o_strobe),
        .o_task_id  (o_task_id),
        .o_run_valid(o_run_valid),
        .o_status   (o_status),
        .o_last     (o_last)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Free one slot of the shadow table
    task automatic drop_slot(input int unsigned s);
        sl_delay[s]  = '0;
        sl_period[s] = '0;
        sl_runs[s]   = '0;
        sl_live[s]   = 1'b0;
    endtask

    task automatic wipe_table();
        for (int unsigned i = 0; i < MAX_TASKS; i++) drop_slot(i);
        sl_next = 0;
    endtask

    // Advance the shadow table by one command and queue the beats it causes
    task automatic schedule_step(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] dly,
                                 input logic [DATA_W-1:0] per, input t_task_id tgt);
        int          n_before;
        int unsigned s;
        sched_beat_t b;
        n_before = expected_beats.size();
        case (cmd)
            CMD_ADD: begin
                if (sl_next < MAX_TASKS) begin
                    s            = sl_next;
                    sl_delay[s]  = dly / 32'(TICK_MS);
                    sl_period[s] = per / 32'(TICK_MS);
                    sl_runs[s]   = '0;
                    sl_live[s]   = 1'b1;
                    sl_next      = s + 1;
                    expected_beats.push_back('{t_task_id'(s), 1'b0, ST_OK, 1'b0});
                end else begin
                    full_adds++;
                    expected_beats.push_back('{t_task_id'(MAX_TASKS), 1'b0, ST_FULL, 1'b0});
                end
            end
            CMD_TICK: begin
                for (s = 0; s < sl_next && s < MAX_TASKS; s++) begin
                    if (sl_live[s]) begin
                        if (sl_delay[s] != 0) begin
                            sl_delay[s]--;
                        end else begin
                            sl_delay[s] = sl_period[s];
                            if (sl_runs[s] != RUNS_MAX) sl_runs[s]++;
                            else sat_ticks++;
                        end
                    end
                end
            end
            CMD_DISPATCH: begin
                for (s = 0; s < sl_next && s < MAX_TASKS; s++) begin
                    if (sl_live[s] && sl_runs[s] != 0) begin
                        expected_beats.push_back('{t_task_id'(s), 1'b1, ST_OK, 1'b0});
                        sl_runs[s]--;
                        if (sl_period[s] == 0) drop_slot(s);
                    end
                end
            end
            CMD_DELETE: begin
                if (tgt < MAX_TASKS && sl_live[tgt]) begin
                    drop_slot(tgt);
                    expected_beats.push_back('{tgt, 1'b0, ST_OK, 1'b0});
                end else begin
                    bad_deletes++;
                    expected_beats.push_back('{tgt, 1'b0, ST_BAD_ID, 1'b0});
                end
            end
            CMD_CLEAR: wipe_table();
            default: ;
        endcase
        // Mark the final beat of this command
        if (expected_beats.size() > n_before) begin
            b = expected_beats.pop_back();
            b.last = 1'b1;
            expected_beats.push_back(b);
        end
    endtask

    // Check result beats, then take in the command accepted at this edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe) begin
                if (expected_beats.size() == 0) begin
                    $error("unexpected result beat: task_id %0d status %0d", o_task_id, o_status);
                    mismatch_count++;
                end else begin
                    want = expected_beats.pop_front();
                    beats_checked++;
                    if (o_run_valid) run_beats++;
                    if (o_task_id !== want.task_id) begin
                        $error("task_id: expected %0d, got %0d", want.task_id, o_task_id);
                        mismatch_count++;
                    end
                    if (o_run_valid !== want.run_valid) begin
                        $error("run_valid: expected %0d, got %0d", want.run_valid, o_run_valid);
                        mismatch_count++;
                    end
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        mismatch_count++;
                    end
                    if (o_last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, o_last);
                        mismatch_count++;
                    end
                end
            end
            if (start && !busy) begin
                cmd_seen[i_cmd]++;
                schedule_step(i_cmd, i_delay_ms, i_period_ms, i_target_id);
                // Typed rows replace the single predicted beat with the written answer
                if (row_typed) begin
                    void'(expected_beats.pop_back());
                    expected_beats.push_back('{row_id, 1'b0, row_status, 1'b1});
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("FAIL cooperative_task_scheduler_core");
            $finish;
        end
    end

    // Idle the command side at random; return at the falling edge that drives the next beat
    task automatic wait_gap();
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            start       = 1'b0;
            i_cmd       = CMD_W'($urandom_range(7));
            i_delay_ms  = $urandom();
            i_period_ms = $urandom();
            i_target_id = TASK_ID_W'($urandom_range(15));
            @(negedge i_clk);
        end
    endtask

    // Present one command beat and hold it until the block takes it
    task automatic put_item(input logic [CMD_W-1:0] c, input logic [DATA_W-1:0] d,
                            input logic [DATA_W-1:0] p, input t_task_id t,
                            input logic typed, input t_task_id tid, input t_status tst);
        start       = 1'b1;
        i_cmd       = c;
        i_delay_ms  = d;
        i_period_ms = p;
        i_target_id = t;
        row_typed   = typed;
        row_id      = tid;
        row_status  = tst;
        do @(posedge i_clk); while (busy);
    endtask

    // Millisecond values: mostly short enough to fire soon, sometimes the extremes
    function automatic logic [DATA_W-1:0] pick_ms();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return $urandom();
            3:       return $urandom_range(1000);
            default: return $urandom_range(60);
        endcase
    endfunction

    // One random command, biased toward sequences that keep tasks alive and firing
    task automatic random_item(output logic counted);
        logic [CMD_W-1:0] c;
        t_task_id         t;
        int               roll;
        wait_gap();
        roll = $urandom_range(99);
        if (sl_next >= MAX_TASKS && roll < 25) c = CMD_CLEAR;
        else if (roll < 24) c = CMD_ADD;
        else if (roll < 54) c = CMD_TICK;
        else if (roll < 74) c = CMD_DISPATCH;
        else if (roll < 86) c = CMD_DELETE;
        else if (roll < 91) c = CMD_CLEAR;
        else c = CMD_W'($urandom_range(CMD_RSVD_HI, CMD_RSVD_LO));
        if (sl_next != 0 && $urandom_range(3) != 0) t = t_task_id'($urandom_range(sl_next - 1));
        else t = t_task_id'($urandom_range(15));
        put_item(c, pick_ms(), pick_ms(), t, 1'b0, '0, ST_OK);
        counted = (c < CMD_RSVD_LO);
    endtask

    initial begin
        logic counted;
        int   done;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_cmd          = CMD_ADD;
        i_delay_ms     = '0;
        i_period_ms    = '0;
        i_target_id    = '0;
        row_typed      = 1'b0;
        row_id         = '0;
        row_status     = ST_OK;
        idle_pct       = 0;
        mismatch_count = 0;
        cycle_count    = 0;
        beats_checked  = 0;
        run_beats      = 0;
        full_adds      = 0;
        bad_deletes    = 0;
        sat_ticks      = 0;
        for (int i = 0; i < 8; i++) cmd_seen[i] = 0;
        wipe_table();

        // Hold reset, then release on a falling edge
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Three idling phases: moderate, heavy, none
        for (int ph = 0; ph < 3; ph++) begin
            idle_pct = (ph == 0) ? 32 : (ph == 1) ? 54 : 0;
            if (ph == 0) begin
                foreach (DIRECTED[r]) begin
                    wait_gap();
                    put_item(DIRECTED[r].cmd, DIRECTED[r].delay_ms, DIRECTED[r].period_ms,
                             DIRECTED[r].target, DIRECTED[r].typed, DIRECTED[r].want_id,
                             DIRECTED[r].want_status);
                end
            end
            done = 0;
            while (done < RAND_ITEMS) begin
                random_item(counted);
                if (counted) done++;
            end
        end

        // Release the command side and drain
        @(negedge i_clk);
        start = 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d adds, %0d ticks, %0d dispatches, %0d deletes, %0d clears, %0d ignored",
                 cmd_seen[CMD_ADD], cmd_seen[CMD_TICK], cmd_seen[CMD_DISPATCH],
                 cmd_seen[CMD_DELETE], cmd_seen[CMD_CLEAR],
                 cmd_seen[5] + cmd_seen[6] + cmd_seen[7]);
        $display("Checked %0d beats: %0d runs, %0d full adds, %0d bad deletes, %0d capped ticks",
                 beats_checked, run_beats, full_adds, bad_deletes, sat_ticks);
        if (mismatch_count == 0) begin
            $display("PASS cooperative_task_scheduler_core");
        end else begin
            $display("FAIL cooperative_task_scheduler_core");
        end
        $finish;
    end

endmodule
